// ===== design/nns_pkg.sv =====
// Shared types and constants for the NV12 nearest-neighbour scaler.
`timescale 1ns / 1ps

package nns_pkg;

  localparam int SIZE_W     = 9;
  localparam int STEP_W     = 25;
  localparam int FRAC_W     = 16;
  localparam int COORD_W    = 8;
  localparam int LADDR_W    = 17;
  localparam int SX_W       = COORD_W + STEP_W - FRAC_W;
  localparam int ADDR_W     = 28;
  localparam int DIV_STEPS  = STEP_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 2;
  localparam int CFG_IDX_W  = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
  localparam logic [STEP_W-1:0] STEP_RESET = 25'd65537;
  localparam logic [SIZE_W-1:0] ALIGN_MASK = 9'h1F8;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_W = 2'd0,
    REG_SRC_H = 2'd1,
    REG_DST_W = 2'd2,
    REG_DST_H = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    RD_LUMA = 2'd0,
    RD_U    = 2'd1,
    RD_V    = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    in_ready;
    logic    cfg_ready;
    logic    mul_en;
    logic    addr_en;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cap_luma;
    logic    cap_u;
    logic    cap_v;
    logic    out_load;
    logic    div_init;
    logic    div_horiz;
    logic    div_step;
  } nns_cmd_t;

  typedef struct packed {
    logic div_last;
    logic outside;
    logic chroma;
    logic out_free;
  } nns_status_t;

endpackage

// ===== design/nns_ctrl.sv =====
// Controller state machine for the NV12 nearest-neighbour scaler.
`timescale 1ns / 1ps

module nns_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_kind,
  input  logic                 cfg_valid,
  input  nns_pkg::nns_status_t status,
  output nns_pkg::nns_cmd_t    cmd
);
  import nns_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ADDR,
    S_RD_Y,
    S_RD_U,
    S_RD_V,
    S_CAP_V,
    S_FINISH,
    S_DIV_H_INIT,
    S_DIV_H_RUN,
    S_DIV_V_INIT,
    S_DIV_V_RUN
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = RD_LUMA;
    state_next     = state;
    case (state)
      S_IDLE: begin
        cmd.cfg_ready = 1'b1;
        cmd.in_ready  = !cfg_valid;
        if (cfg_valid) begin
          state_next = S_DIV_H_INIT;
        end else if (in_valid && in_kind == KIND_FETCH) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr_en = 1'b1;
        state_next  = status.outside ? S_FINISH : S_RD_Y;
      end
      S_RD_Y: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_LUMA;
        state_next = S_RD_U;
      end
      S_RD_U: begin
        cmd.cap_luma = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_U;
        state_next   = status.chroma ? S_RD_V : S_FINISH;
      end
      S_RD_V: begin
        cmd.cap_u  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_V;
        state_next = S_CAP_V;
      end
      S_CAP_V: begin
        cmd.cap_v  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DIV_H_INIT: begin
        cmd.div_init  = 1'b1;
        cmd.div_horiz = 1'b1;
        state_next    = S_DIV_H_RUN;
      end
      S_DIV_H_RUN: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DIV_V_INIT;
        end
      end
      S_DIV_V_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV_V_RUN;
      end
      S_DIV_V_RUN: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_no_dual_accept: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && cmd.in_ready && cfg_valid && cmd.cfg_ready))
    else $error("input and configuration transactions taken together");

  a_finish_returns: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && status.out_free) |=> state == S_IDLE)
    else $error("result hand-off did not return to idle");

  a_outside_no_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADDR && status.outside) |=> state == S_FINISH)
    else $error("flagged pixel went on to read the frame store");

  a_divide_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_V_RUN && status.div_last) |=> (state == S_IDLE && cmd.in_ready == !cfg_valid))
    else $error("step recompute did not end in idle");

endmodule

// ===== design/nns_dp.sv =====
// Datapath for the NV12 nearest-neighbour scaler: sizes, steps, frame store, result register.
`timescale 1ns / 1ps

module nns_dp #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  nns_pkg::nns_cmd_t             cmd,
  output nns_pkg::nns_status_t          status,
  input  logic                          in_valid,
  input  logic                          in_kind,
  input  logic [nns_pkg::LADDR_W-1:0]   load_address,
  input  logic [7:0]                    load_byte,
  input  logic [nns_pkg::COORD_W-1:0]   pixel_column,
  input  logic [nns_pkg::COORD_W-1:0]   pixel_row,
  input  logic                          cfg_valid,
  input  logic [nns_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nns_pkg::SIZE_W-1:0]    cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic                          out_chroma,
  output logic [7:0]                    out_luma,
  output logic [7:0]                    out_u,
  output logic [7:0]                    out_v
);
  import nns_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * 3 / 2;
  localparam int AW    = $clog2(DEPTH);

  logic [SIZE_W-1:0] src_w, src_h, dst_w, dst_h;
  logic [STEP_W-1:0] hstep, vstep;

  logic [7:0] store [DEPTH];

  logic                in_accept;
  logic [ADDR_W-1:0]   load_full;
  logic [COORD_W-1:0]  x, y;
  logic [SX_W-1:0]     sx, sy;
  logic                outside, chroma;
  logic [2*SIZE_W-1:0] plane;
  logic [ADDR_W-1:0]   luma_addr, pair_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic [7:0]          mem_q;
  logic                rd_zero;
  logic [7:0]          rd_value;
  logic [7:0]          res_luma, res_u, res_v;

  logic [COORD_W+STEP_W-1:0] prod_x, prod_y;
  logic [SX_W+SIZE_W-1:0]    prod_luma;
  logic [SX_W+SIZE_W-2:0]    prod_half;

  logic [SIZE_W-1:0]    div_rem;
  logic [STEP_W-1:0]    div_quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_horiz;
  logic [SIZE_W-1:0]    divisor;
  logic [SIZE_W:0]      trial, diff;
  logic                 ge;
  logic [STEP_W-1:0]    quo_next;
  logic [STEP_W-1:0]    step_new;

  assign in_accept = in_valid && cmd.in_ready;
  assign load_full = ADDR_W'(load_address);

  // Configuration registers and step recompute
  assign divisor  = div_horiz ? dst_w : dst_h;
  assign trial    = {div_rem, div_quo[STEP_W-1]};
  assign diff     = trial - {1'b0, divisor};
  assign ge       = trial >= {1'b0, divisor};
  assign quo_next = {div_quo[STEP_W-2:0], ge};
  assign step_new = (divisor == '0) ? '0 : quo_next + STEP_W'(1);
  assign status.div_last = div_cnt == DIV_CNT_W'(DIV_STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= SIZE_RESET;
      src_h <= SIZE_RESET;
      dst_w <= SIZE_RESET;
      dst_h <= SIZE_RESET;
      hstep <= STEP_RESET;
      vstep <= STEP_RESET;
    end else begin
      if (cfg_valid && cmd.cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_SRC_W: src_w <= cfg_data;
          REG_SRC_H: src_h <= cfg_data;
          REG_DST_W: dst_w <= cfg_data;
          REG_DST_H: dst_h <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.div_step && status.div_last) begin
        if (div_horiz) begin
          hstep <= step_new;
        end else begin
          vstep <= step_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_horiz <= cmd.div_horiz;
      div_rem   <= '0;
      div_cnt   <= '0;
      div_quo   <= cmd.div_horiz ? {src_w, {FRAC_W{1'b0}}} : {src_h, {FRAC_W{1'b0}}};
    end else if (cmd.div_step) begin
      div_rem <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
      div_quo <= quo_next;
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // Frame store
  always_ff @(posedge clk) begin
    if (in_accept && in_kind == KIND_LOAD && load_full < ADDR_W'(DEPTH)) begin
      store[load_full[AW-1:0]] <= load_byte;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_LUMA: rd_addr = luma_addr;
      RD_U:    rd_addr = pair_addr;
      RD_V:    rd_addr = pair_addr + ADDR_W'(1);
      default: rd_addr = luma_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_zero <= rd_addr >= ADDR_W'(DEPTH);
      if (rd_addr < ADDR_W'(DEPTH)) begin
        mem_q <= store[rd_addr[AW-1:0]];
      end
    end
  end

  assign rd_value = rd_zero ? 8'd0 : mem_q;

  // Coordinate mapping
  assign prod_x    = {{STEP_W{1'b0}}, x} * {{COORD_W{1'b0}}, hstep};
  assign prod_y    = {{STEP_W{1'b0}}, y} * {{COORD_W{1'b0}}, vstep};
  assign prod_luma = {{SIZE_W{1'b0}}, sy} * {{SX_W{1'b0}}, src_w};
  assign prod_half = {{SIZE_W{1'b0}}, sy[SX_W-1:1]} * {{(SX_W-1){1'b0}}, src_w};

  always_ff @(posedge clk) begin
    plane <= {{SIZE_W{1'b0}}, src_h} * {{SIZE_W{1'b0}}, src_w};
    if (in_accept) begin
      x <= pixel_column;
      y <= pixel_row;
    end
    if (cmd.mul_en) begin
      sx      <= prod_x[COORD_W+STEP_W-1:FRAC_W];
      sy      <= prod_y[COORD_W+STEP_W-1:FRAC_W];
      outside <= ({1'b0, x} >= (dst_w & ALIGN_MASK)) || ({1'b0, y} >= (dst_h & ALIGN_MASK));
      chroma  <= !x[0] && !y[0];
    end
    if (cmd.addr_en) begin
      luma_addr <= ADDR_W'(prod_luma) + ADDR_W'(sx);
      pair_addr <= ADDR_W'(plane) + ADDR_W'(prod_half) + ADDR_W'({sx[SX_W-1:1], 1'b0});
    end
    if (cmd.cap_luma) begin
      res_luma <= rd_value;
    end
    if (cmd.cap_u) begin
      res_u <= rd_value;
    end
    if (cmd.cap_v) begin
      res_v <= rd_value;
    end
  end

  assign status.outside  = outside;
  assign status.chroma   = chroma;
  assign status.out_free = !out_valid || out_ready;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= outside;
      out_chroma <= !outside && chroma;
      out_luma   <= outside ? 8'd0 : res_luma;
      out_u      <= (outside || !chroma) ? 8'd0 : res_u;
      out_v      <= (outside || !chroma) ? 8'd0 : res_v;
    end
  end

endmodule

// ===== design/nv12_nearest_neighbor_scaler_top.sv =====
// Top level of the NV12 nearest-neighbour scaler.
`timescale 1ns / 1ps

// Source frame bytes and pixel fetches arrive on the s_ stream; s_tuser picks the
// transaction kind (0 load one frame store byte, 1 fetch one destination pixel).
// Each fetch returns one result on the m_ stream; loads return nothing.
// Sizes are written on the cfg_ channel while no work is outstanding; each write
// re-derives both 9.16 steps with a one-bit-per-cycle divider, holding s_tready
// and cfg_ready low until both divisions are done.
// A load is taken in idle. A fetch runs the multiply and address stages and then
// reads the frame store one byte at a time through its single read port; a pixel
// flagged outside skips the reads. The block takes no new transaction until the
// fetch has loaded its result into the output register.
// A stalled receiver holds the result in the output register; a following fetch
// finishes its work and then waits until the register is free to load its result,
// taking no new transaction while it waits.
// Reset restores all sizes to 256 with matching steps; the frame store contents are
// undefined until loaded.
module nv12_nearest_neighbor_scaler_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [nns_pkg::IN_DATA_W-1:0]     s_tdata,   // load_address, load_byte, pixel_column, pixel_row
  input  logic                              s_tuser,   // kind
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [nns_pkg::OUT_DATA_W-1:0]    m_tdata,   // luma_value, u_value, v_value
  output logic [nns_pkg::OUT_USER_W-1:0]    m_tuser,   // status, chroma_present
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nns_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nns_pkg::SIZE_W-1:0]        cfg_data
);
  import nns_pkg::*;

  nns_cmd_t    cmd;
  nns_status_t status;
  logic        out_status, out_chroma;
  logic [7:0]  out_luma, out_u, out_v;

  assign s_tready  = cmd.in_ready;
  assign cfg_ready = cmd.cfg_ready;
  assign m_tdata   = {out_v, out_u, out_luma};
  assign m_tuser   = {out_chroma, out_status};

  nns_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_kind   (s_tuser),
    .cfg_valid (cfg_valid),
    .status    (status),
    .cmd       (cmd)
  );

  nns_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_valid     (s_tvalid),
    .in_kind      (s_tuser),
    .load_address (s_tdata[16:0]),
    .load_byte    (s_tdata[24:17]),
    .pixel_column (s_tdata[32:25]),
    .pixel_row    (s_tdata[40:33]),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_status   (out_status),
    .out_chroma   (out_chroma),
    .out_luma     (out_luma),
    .out_u        (out_u),
    .out_v        (out_v)
  );

endmodule
